/* rtl/line_rasterizer_unit_defines.svh */
// Assertion macros used by the line rasterizer controller.
`ifndef LINE_RASTERIZER_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LRU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lru_pkg.sv */
// Shared constants and types of the line rasterizer.
`default_nettype none
package lru_pkg;

	localparam int COORD_BITS = 6;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS   = COORD_BITS + 3;
	localparam int COLOR_BITS = 8;
	localparam int INDEX_BITS = 2;

	localparam logic [INDEX_BITS-1:0] REG_RED   = 2'd0;
	localparam logic [INDEX_BITS-1:0] REG_GREEN = 2'd1;
	localparam logic [INDEX_BITS-1:0] REG_BLUE  = 2'd2;

	localparam logic [1:0] STEP_ZERO = 2'b00;
	localparam logic [1:0] STEP_POS  = 2'b01;
	localparam logic [1:0] STEP_NEG  = 2'b11;

	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic at_end;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/line_rasterizer_unit.sv */
// Top level of the Bresenham line rasterizer.
// Usage:
//   Input channel (in_valid / in_stall) carries one segment: start_x, start_y,
//   end_x, end_y. A transfer happens when in_valid is high and in_stall low.
//   Output channel (out_valid / out_stall) carries one pixel per transfer with
//   its coordinates, the configured colour and last_pixel on the end point.
//   The user must write colour registers through cfg_we / cfg_index / cfg_data
//   (0 red, 1 green, 2 blue; other indexes ignored) only while idle; not enforced.
// Timing:
//   The segment is loaded at its transfer and the draw state then registers
//   pixels, one per cycle while the receiver takes them; the single error-term
//   update per cycle in the datapath sets this rate. A segment has N pixels
//   (N = max(|dx|,|dy|) + 1, at most 64). in_stall is high while a segment is
//   being drawn.
// Reset and stall:
//   Reset clears the colour registers to zero and returns the block to idle
//   with no pixel pending. While out_stall is high and a pixel is pending, that
//   pixel holds and drawing pauses.
`default_nettype none
module line_rasterizer_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [lru_pkg::COORD_BITS-1:0] start_x,
	input  wire logic [lru_pkg::COORD_BITS-1:0] start_y,
	input  wire logic [lru_pkg::COORD_BITS-1:0] end_x,
	input  wire logic [lru_pkg::COORD_BITS-1:0] end_y,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [lru_pkg::COORD_BITS-1:0]      pixel_x,
	output logic [lru_pkg::COORD_BITS-1:0]      pixel_y,
	output logic [lru_pkg::COLOR_BITS-1:0]      pixel_red,
	output logic [lru_pkg::COLOR_BITS-1:0]      pixel_green,
	output logic [lru_pkg::COLOR_BITS-1:0]      pixel_blue,
	output logic                                last_pixel,
	input  wire logic                           cfg_we,
	input  wire logic [lru_pkg::INDEX_BITS-1:0] cfg_index,
	input  wire logic [lru_pkg::COLOR_BITS-1:0] cfg_data
);

	lru_pkg::cmd_t cmd;
	lru_pkg::sts_t sts;

	lru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lru_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_red   (pixel_red),
		.pixel_green (pixel_green),
		.pixel_blue  (pixel_blue),
		.last_pixel  (last_pixel)
	);

endmodule
`default_nettype wire

/* rtl/lru_datapath.sv */
// Datapath: endpoint capture, Bresenham error term, colour and output registers.
`default_nettype none
module lru_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire lru_pkg::cmd_t                       cmd,
	output lru_pkg::sts_t                            sts,
	input  wire logic [lru_pkg::COORD_BITS-1:0]      start_x,
	input  wire logic [lru_pkg::COORD_BITS-1:0]      start_y,
	input  wire logic [lru_pkg::COORD_BITS-1:0]      end_x,
	input  wire logic [lru_pkg::COORD_BITS-1:0]      end_y,
	input  wire logic                                cfg_we,
	input  wire logic [lru_pkg::INDEX_BITS-1:0]      cfg_index,
	input  wire logic [lru_pkg::COLOR_BITS-1:0]      cfg_data,
	output logic [lru_pkg::COORD_BITS-1:0]           pixel_x,
	output logic [lru_pkg::COORD_BITS-1:0]           pixel_y,
	output logic [lru_pkg::COLOR_BITS-1:0]           pixel_red,
	output logic [lru_pkg::COLOR_BITS-1:0]           pixel_green,
	output logic [lru_pkg::COLOR_BITS-1:0]           pixel_blue,
	output logic                                     last_pixel
);

	localparam int C = lru_pkg::COORD_BITS;
	localparam int D = lru_pkg::DELTA_BITS;
	localparam int E = lru_pkg::ERR_BITS;
	localparam int K = lru_pkg::COLOR_BITS;

	logic [K-1:0] red_q, green_q, blue_q;

	logic [C-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic signed [E-1:0] err_q;
	logic [D-1:0] tdx_q, tdy_q;
	logic [1:0] sx_q, sy_q;
	logic xmaj_q;

	logic [C-1:0] px_q, py_q;
	logic [K-1:0] pr_q, pg_q, pb_q;
	logic last_q;

	// set-up values from the incoming endpoints
	logic signed [C:0] dx_d, dy_d;
	logic [C-1:0] dx_mag, dy_mag;
	logic [D-1:0] tdx_d, tdy_d;
	logic [1:0] sx_d, sy_d;
	logic xmaj_d;
	logic signed [E-1:0] err_init;

	// per-pixel step values
	logic maj_pos, take_minor;
	logic [D-1:0] tmaj, tmin;
	logic signed [E-1:0] err_next;
	logic [C-1:0] cur_x_next, cur_y_next;

	always_comb begin
		dx_d   = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy_d   = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		dx_mag = dx_d[C] ? C'(-dx_d) : dx_d[C-1:0];
		dy_mag = dy_d[C] ? C'(-dy_d) : dy_d[C-1:0];
		tdx_d  = {dx_mag, 1'b0};
		tdy_d  = {dy_mag, 1'b0};
		sx_d   = (dx_d == '0) ? lru_pkg::STEP_ZERO : (dx_d[C] ? lru_pkg::STEP_NEG : lru_pkg::STEP_POS);
		sy_d   = (dy_d == '0) ? lru_pkg::STEP_ZERO : (dy_d[C] ? lru_pkg::STEP_NEG : lru_pkg::STEP_POS);
		xmaj_d = tdx_d >= tdy_d;
		if (xmaj_d) begin
			err_init = $signed(E'(tdy_d)) - $signed(E'(dx_mag));
		end else begin
			err_init = $signed(E'(tdx_d)) - $signed(E'(dy_mag));
		end
	end

	always_comb begin
		maj_pos    = xmaj_q ? (sx_q == lru_pkg::STEP_POS) : (sy_q == lru_pkg::STEP_POS);
		// symmetric tie-break: a zero error term steps only on a positive major step
		take_minor = (!err_q[E-1] && (err_q != '0)) || ((err_q == '0) && maj_pos);
		tmaj       = xmaj_q ? tdx_q : tdy_q;
		tmin       = xmaj_q ? tdy_q : tdx_q;
		err_next   = err_q - (take_minor ? $signed(E'(tmaj)) : $signed(E'(0)))
			+ $signed(E'(tmin));
		cur_x_next = cur_x_q;
		cur_y_next = cur_y_q;
		if (xmaj_q || take_minor) begin
			cur_x_next = cur_x_q + {{(C-1){sx_q[1]}}, sx_q[0]};
		end
		if (!xmaj_q || take_minor) begin
			cur_y_next = cur_y_q + {{(C-1){sy_q[1]}}, sy_q[0]};
		end
		sts.at_end = xmaj_q ? (cur_x_q == tgt_x_q) : (cur_y_q == tgt_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lru_pkg::REG_RED:   red_q   <= cfg_data;
				lru_pkg::REG_GREEN: green_q <= cfg_data;
				lru_pkg::REG_BLUE:  blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q <= start_x;
			cur_y_q <= start_y;
			tgt_x_q <= end_x;
			tgt_y_q <= end_y;
			tdx_q   <= tdx_d;
			tdy_q   <= tdy_d;
			sx_q    <= sx_d;
			sy_q    <= sy_d;
			xmaj_q  <= xmaj_d;
			err_q   <= err_init;
		end else if (cmd.emit) begin
			cur_x_q <= cur_x_next;
			cur_y_q <= cur_y_next;
			err_q   <= err_next;
		end
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			px_q   <= cur_x_q;
			py_q   <= cur_y_q;
			pr_q   <= red_q;
			pg_q   <= green_q;
			pb_q   <= blue_q;
			last_q <= sts.at_end;
		end
	end

	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_red   = pr_q;
	assign pixel_green = pg_q;
	assign pixel_blue  = pb_q;
	assign last_pixel  = last_q;

endmodule
`default_nettype wire

/* rtl/lru_ctrl.sv */
// Controller: segment state machine and output valid flag.
`default_nettype none
`include "line_rasterizer_unit_defines.svh"
module lru_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire lru_pkg::sts_t sts,
	output lru_pkg::cmd_t      cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DRAW = 1'b1;

	logic state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (sts.at_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`LRU_ASSERT(a_load_emit_excl, !(cmd.load && cmd.emit), "load and emit in one cycle")
	`LRU_ASSERT(a_emit_free, !cmd.emit || out_free, "pixel overwritten while stalled")
	`LRU_ASSERT_NEXT(a_accept_draw, in_valid && !in_stall, state_q == ST_DRAW,
		"accepted segment not drawn")
	`LRU_ASSERT_NEXT(a_end_idle, cmd.emit && sts.at_end, state_q == ST_IDLE && out_valid,
		"end point did not finish the segment")

endmodule
`default_nettype wire
